// ----- design/swms_pkg.sv -----
// ----------------------------------------------------------------------------
// swms_pkg: shared definitions for the swerve module setpoint core
// Field widths, register codes, reset values and the structs that pass
// between the core and its submodules.
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int WHEEL_W   = 2;
    localparam int SPEED_W   = 16;
    localparam int HEAD_W    = 22;
    localparam int MEAS_W    = 32;
    localparam int ERPM_W    = 32;

    localparam int CPR_W     = 21;
    localparam int FLIP_W    = 20;
    localparam int DB_W      = 15;
    localparam int GAIN_W    = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Heading error in (-cpr, cpr) as two's complement
    localparam int ERR_W     = CPR_W + 1;
    // Speed magnitude times gain, Q8 fraction dropped
    localparam int PROD_W    = SPEED_W + GAIN_W;
    localparam int EMAG_W    = PROD_W - 8;

    // Number of heading error register stages
    localparam int HEAD_LAT  = 4;

    // Dividend bits retired per remainder stage
    localparam int MOD_STEP_DEFAULT = 4;

    localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(8192);
    localparam logic [FLIP_W-1:0] FLIP_RESET = FLIP_W'(2162);
    localparam logic [DB_W-1:0]   DB_RESET   = DB_W'(10);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTS_PER_REV = 2'd0,
        REG_FLIP_THRESHOLD = 2'd1,
        REG_SPEED_DEADBAND = 2'd2,
        REG_ERPM_GAIN      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic meas_neg;
        logic head_neg;
    } sign_t;

    typedef struct packed {
        logic [WHEEL_W-1:0] wheel;
        logic [MEAS_W-1:0]  meas;
        logic               spd_neg;
        logic [SPEED_W-1:0] spd_mag;
        sign_t              signs;
        logic               held;
        logic [EMAG_W-1:0]  erpm_mag;
    } side_t;

endpackage

// ----- design/swms_mod_pipe.sv -----
// ----------------------------------------------------------------------------
// swms_mod_pipe: pipelined unsigned remainder
// Restoring remainder of dividend by divisor, STEP dividend bits per stage,
// one new operand accepted every cycle.
// ----------------------------------------------------------------------------
module swms_mod_pipe #(
    parameter int W    = swms_pkg::MEAS_W,
    parameter int STEP = swms_pkg::MOD_STEP_DEFAULT
) (
    input  logic                       clk,
    input  logic [W-1:0]               dividend,
    input  logic [swms_pkg::CPR_W-1:0] divisor,
    output logic [swms_pkg::CPR_W-1:0] rem
);
    import swms_pkg::*;

    localparam int NS = W / STEP;

    logic [W-1:0]     num_reg [NS-1];
    logic [CPR_W-1:0] rem_reg [NS];

    // Shift in STEP bits, subtract the divisor whenever it fits
    function automatic logic [CPR_W-1:0] mod_bits(
        input logic [CPR_W-1:0] r_in,
        input logic [STEP-1:0]  bits,
        input logic [CPR_W-1:0] d
    );
        logic [CPR_W:0]   acc;
        logic [CPR_W-1:0] r;
        r = r_in;
        for (int i = STEP - 1; i >= 0; i--)
        begin
            acc = {r, bits[i]};
            if (acc >= {1'b0, d})
            begin
                acc = acc - {1'b0, d};
            end
            r = acc[CPR_W-1:0];
        end
        return r;
    endfunction

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [W-1:0]     num_in;
        logic [CPR_W-1:0] rem_in;
        logic [CPR_W-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign num_in = dividend;
            assign rem_in = '0;
        end
        else
        begin : g_rest
            assign num_in = num_reg[s-1];
            assign rem_in = rem_reg[s-1];
        end

        assign rem_next = mod_bits(rem_in, num_in[W-1 -: STEP], divisor);

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
        end

        if (s < NS - 1)
        begin : g_num
            always_ff @(posedge clk)
            begin
                num_reg[s] <= num_in << STEP;
            end
        end
    end

    assign rem = rem_reg[NS-1];

endmodule

// ----- design/swms_heading.sv -----
// ----------------------------------------------------------------------------
// swms_heading: heading error and drive flip
// Turns both remainders into a wrapped heading error, applies the
// shortest-path flip and reports whether the drive is reversed.
// ----------------------------------------------------------------------------
module swms_heading (
    input  logic                        clk,
    input  logic [swms_pkg::CPR_W-1:0]  rem_meas,
    input  logic [swms_pkg::CPR_W-1:0]  rem_head,
    input  swms_pkg::sign_t             signs,
    input  logic [swms_pkg::CPR_W-1:0]  cpr,
    input  logic [swms_pkg::FLIP_W-1:0] flip,
    output logic [swms_pkg::ERR_W-1:0]  err,
    output logic                        rev
);
    import swms_pkg::*;

    logic [CPR_W-1:0] hm_reg, hm_next;
    logic [CPR_W-1:0] hh_reg, hh_next;
    logic [CPR_W:0]   diff;
    logic [CPR_W:0]   diff_wrap;
    logic [CPR_W-1:0] e1_reg, e1_next;
    logic             wrap;
    logic [ERR_W-1:0] e2_reg, e2_next;
    logic [CPR_W-1:0] emag_reg, emag_next;
    logic [ERR_W-1:0] half;
    logic             flip_hit;
    logic [ERR_W-1:0] err_reg, err_next;
    logic             rev_reg;

    // Floor modulo: a negative operand with a nonzero remainder folds to cpr - rem
    assign hm_next = (signs.meas_neg && rem_meas != '0) ? cpr - rem_meas : rem_meas;
    assign hh_next = (signs.head_neg && rem_head != '0) ? cpr - rem_head : rem_head;

    // Difference of two values in [0, cpr), brought back into [0, cpr)
    assign diff      = {1'b0, hh_reg} - {1'b0, hm_reg};
    assign diff_wrap = diff + {1'b0, cpr};
    assign e1_next   = diff[CPR_W] ? diff_wrap[CPR_W-1:0] : diff[CPR_W-1:0];

    // Wrap into (-cpr/2, cpr/2], keep the magnitude alongside
    assign wrap      = {e1_reg, 1'b0} > {1'b0, cpr};
    assign e2_next   = wrap ? ({1'b0, e1_reg} - {1'b0, cpr}) : {1'b0, e1_reg};
    assign emag_next = wrap ? (cpr - e1_reg) : e1_reg;

    // Shift by half a revolution toward zero when past the threshold
    assign half     = {1'b0, cpr >> 1};
    assign flip_hit = emag_reg > {1'b0, flip};
    assign err_next = !flip_hit         ? e2_reg :
                      e2_reg[ERR_W-1]   ? e2_reg + half :
                                          e2_reg - half;

    always_ff @(posedge clk)
    begin
        hm_reg   <= hm_next;
        hh_reg   <= hh_next;
        e1_reg   <= e1_next;
        e2_reg   <= e2_next;
        emag_reg <= emag_next;
        err_reg  <= err_next;
        rev_reg  <= flip_hit;
    end

    assign err = err_reg;
    assign rev = rev_reg;

endmodule

// ----- design/swerve_module_setpoint_core.sv -----
// ----------------------------------------------------------------------------
// swerve_module_setpoint_core: steering target and drive ERPM for one wheel
// Shortest-path steering setpoint with drive reversal and speed deadband.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive wheel_id, target_speed, target_heading and
//   measured_total with start high; the item is taken at that clock edge
//   when busy is low. busy stays low: an item may enter in every cycle.
//   Result channel: done is high for exactly one cycle with wheel_out,
//   steer_target, drive_erpm, reversed and held valid in that cycle. The
//   receiver cannot hold results off; every item yields one result, in order.
//   Path: an item passes the input register, the two remainder pipelines
//   (measured count and target heading modulo counts per revolution, each
//   retiring MOD_STEP dividend bits per stage, four by default), four
//   heading error stages and the output register before done rises.
//   Throughput: one item per cycle.
//   Configuration: cfg_we, cfg_index and cfg_data write one register per
//   edge; write only while no item is in flight. A counts per revolution of
//   zero is stored as one.
//   Reset: rst_n clears the pipeline valid bits and loads the register
//   defaults; items in flight are dropped and done stays low.
// ----------------------------------------------------------------------------
module swerve_module_setpoint_core #(
    parameter int MOD_STEP = swms_pkg::MOD_STEP_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [swms_pkg::WHEEL_W-1:0]      wheel_id,
    input  logic signed [swms_pkg::SPEED_W-1:0] target_speed,
    input  logic signed [swms_pkg::HEAD_W-1:0]  target_heading,
    input  logic signed [swms_pkg::MEAS_W-1:0]  measured_total,
    input  logic                              cfg_we,
    input  logic [swms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swms_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              done,
    output logic [swms_pkg::WHEEL_W-1:0]      wheel_out,
    output logic signed [swms_pkg::MEAS_W-1:0]  steer_target,
    output logic signed [swms_pkg::ERPM_W-1:0]  drive_erpm,
    output logic                              reversed,
    output logic                              held
);
    import swms_pkg::*;

    // Remainder stages, then heading stages, all tracked by the side line
    localparam int MOD_STAGES = MEAS_W / MOD_STEP;
    localparam int SB_DEPTH   = MOD_STAGES + HEAD_LAT + 1;

    // ---------------- configuration registers ----------------
    logic [CPR_W-1:0]  cpr_reg;
    logic [FLIP_W-1:0] flip_reg;
    logic [DB_W-1:0]   db_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Store a zero revolution count as one so the remainder never divides by zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg  <= CPR_RESET;
            flip_reg <= FLIP_RESET;
            db_reg   <= DB_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COUNTS_PER_REV:
                begin
                    cpr_reg <= (cfg_data[CPR_W-1:0] == '0) ? CPR_W'(1)
                                                           : cfg_data[CPR_W-1:0];
                end
                REG_FLIP_THRESHOLD: flip_reg <= cfg_data[FLIP_W-1:0];
                REG_SPEED_DEADBAND: db_reg   <= cfg_data[DB_W-1:0];
                REG_ERPM_GAIN:      gain_reg <= cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- input stage ----------------
    // The pipeline never stalls, so an item is taken whenever start is high
    logic               accept;
    logic [MEAS_W-1:0]  abs_meas_reg, abs_meas_next;
    logic [MEAS_W-1:0]  abs_head_reg, abs_head_next;
    logic [HEAD_W-1:0]  head_neg_val;
    logic [SPEED_W-1:0] spd_mag_next;
    side_t              side_in;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Magnitudes feed the unsigned remainder pipes; signs ride the side line
    assign abs_meas_next = measured_total[MEAS_W-1] ? (~measured_total + 1'b1)
                                                    : measured_total;
    assign head_neg_val  = ~target_heading + 1'b1;
    assign abs_head_next = target_heading[HEAD_W-1] ? MEAS_W'(head_neg_val)
                                                    : MEAS_W'(target_heading);
    assign spd_mag_next  = target_speed[SPEED_W-1] ? (~target_speed + 1'b1)
                                                   : target_speed;

    always_comb
    begin
        side_in                = '0;
        side_in.wheel          = wheel_id;
        side_in.meas           = measured_total;
        side_in.spd_neg        = target_speed[SPEED_W-1];
        side_in.spd_mag        = spd_mag_next;
        side_in.signs.meas_neg = measured_total[MEAS_W-1];
        side_in.signs.head_neg = target_heading[HEAD_W-1];
    end

    always_ff @(posedge clk)
    begin
        abs_meas_reg <= abs_meas_next;
        abs_head_reg <= abs_head_next;
    end

    // ---------------- side line: valid bits and pass-through data ----------------
    logic              vld_reg [SB_DEPTH];
    side_t             sb_reg  [SB_DEPTH];
    side_t             sb_stage1_next;
    logic [PROD_W-1:0] prod;

    // Second stage: deadband test and the ERPM magnitude product
    assign prod = sb_reg[0].spd_mag * gain_reg;

    always_comb
    begin
        sb_stage1_next          = sb_reg[0];
        sb_stage1_next.held     = {1'b0, sb_reg[0].spd_mag} < {2'b00, db_reg};
        sb_stage1_next.erpm_mag = prod[PROD_W-1:8];
    end

    for (genvar i = 0; i < SB_DEPTH; i++)
    begin : g_side
        logic vld_in;

        if (i == 0)
        begin : g_vld_first
            assign vld_in = accept;
        end
        else
        begin : g_vld_rest
            assign vld_in = vld_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        if (i == 0)
        begin : g_in
            always_ff @(posedge clk)
            begin
                sb_reg[i] <= side_in;
            end
        end
        else if (i == 1)
        begin : g_mul
            always_ff @(posedge clk)
            begin
                sb_reg[i] <= sb_stage1_next;
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    // ---------------- remainder pipes ----------------
    logic [CPR_W-1:0] rem_meas;
    logic [CPR_W-1:0] rem_head;

    swms_mod_pipe #(
        .W    (MEAS_W),
        .STEP (MOD_STEP)
    ) u_mod_meas (
        .clk      (clk),
        .dividend (abs_meas_reg),
        .divisor  (cpr_reg),
        .rem      (rem_meas)
    );

    swms_mod_pipe #(
        .W    (MEAS_W),
        .STEP (MOD_STEP)
    ) u_mod_head (
        .clk      (clk),
        .dividend (abs_head_reg),
        .divisor  (cpr_reg),
        .rem      (rem_head)
    );

    // ---------------- heading error and flip ----------------
    logic [ERR_W-1:0] err;
    logic             rev;

    swms_heading u_heading (
        .clk      (clk),
        .rem_meas (rem_meas),
        .rem_head (rem_head),
        .signs    (sb_reg[MOD_STAGES].signs),
        .cpr      (cpr_reg),
        .flip     (flip_reg),
        .err      (err),
        .rev      (rev)
    );

    // ---------------- output stage ----------------
    side_t              sb_last;
    logic [MEAS_W:0]    steer_sum;
    logic [MEAS_W-1:0]  steer_sat;
    logic               erpm_neg;
    logic [ERPM_W-1:0]  erpm_ext;
    logic [ERPM_W-1:0]  erpm_val;

    logic               done_reg;
    logic [WHEEL_W-1:0] wheel_reg,    wheel_next;
    logic [MEAS_W-1:0]  steer_reg,    steer_next;
    logic [ERPM_W-1:0]  erpm_reg,     erpm_next;
    logic               reversed_reg, reversed_next;
    logic               held_reg,     held_next;

    assign sb_last = sb_reg[SB_DEPTH-1];

    // Measured count plus error, clamped to the 32-bit range
    assign steer_sum = {sb_last.meas[MEAS_W-1], sb_last.meas}
                     + {{(MEAS_W + 1 - ERR_W){err[ERR_W-1]}}, err};
    assign steer_sat = (steer_sum[MEAS_W] == steer_sum[MEAS_W-1]) ? steer_sum[MEAS_W-1:0] :
                       steer_sum[MEAS_W] ? {1'b1, {(MEAS_W - 1){1'b0}}}
                                         : {1'b0, {(MEAS_W - 1){1'b1}}};

    // Truncated magnitude carries the speed sign, flipped again on reversal
    assign erpm_neg = sb_last.spd_neg ^ rev;
    assign erpm_ext = ERPM_W'(sb_last.erpm_mag);
    assign erpm_val = erpm_neg ? (~erpm_ext + 1'b1) : erpm_ext;

    always_comb
    begin
        wheel_next = sb_last.wheel;
        held_next  = sb_last.held;
        if (sb_last.held)
        begin
            steer_next    = sb_last.meas;
            erpm_next     = '0;
            reversed_next = 1'b0;
        end
        else
        begin
            steer_next    = steer_sat;
            erpm_next     = erpm_val;
            reversed_next = rev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[SB_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        wheel_reg    <= wheel_next;
        steer_reg    <= steer_next;
        erpm_reg     <= erpm_next;
        reversed_reg <= reversed_next;
        held_reg     <= held_next;
    end

    assign done         = done_reg;
    assign wheel_out    = wheel_reg;
    assign steer_target = steer_reg;
    assign drive_erpm   = erpm_reg;
    assign reversed     = reversed_reg;
    assign held         = held_reg;

endmodule
